@@ hdl/rpd_pkg.sv @@
// Shared constants and types for the remote packet deframer.
package rpd_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    typedef enum logic [1:0] {
        STATUS_NONE = 2'd0,
        STATUS_GOOD = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        status_t     packet_status;
        logic [15:0] data_word;
    } result_t;

endpackage

@@ hdl/rpd_if.sv @@
// Valid/ready channel interfaces for received bytes and deframed results.
interface rpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rpd_result_if;
    logic             valid;
    logic             ready;
    rpd_pkg::status_t packet_status;
    logic [15:0]      data_word;

    modport source (output valid, output packet_status, output data_word, input ready);
    modport sink   (input valid, input packet_status, input data_word, output ready);
endinterface

@@ hdl/rpd_framer.sv @@
// Packet framing state machine: tracks the byte position and checks complements.
module rpd_framer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output rpd_pkg::result_t result
);
    import rpd_pkg::*;

    typedef enum logic [2:0] {
        POS_HUNT     = 3'd0,
        POS_HDR2     = 3'd1,
        POS_LOW      = 3'd2,
        POS_LOW_CHK  = 3'd3,
        POS_HIGH     = 3'd4,
        POS_HIGH_CHK = 3'd5
    } pos_t;

    pos_t       pos_reg,      pos_next;
    logic [7:0] low_reg,      low_next;
    logic       low_ok_reg,   low_ok_next;
    logic [7:0] high_reg,     high_next;
    logic [7:0] inv_byte;

    assign inv_byte = ~rx_byte;

    always_comb
    begin
        pos_next             = POS_HUNT;
        low_next             = low_reg;
        low_ok_next          = low_ok_reg;
        high_next            = high_reg;
        result.packet_status = STATUS_NONE;
        result.data_word     = 16'h0000;
        case (pos_reg)
            POS_HDR2:
            begin
                if (rx_byte == HDR_SECOND)
                    pos_next = POS_LOW;
                else if (rx_byte == HDR_FIRST)
                    pos_next = POS_HDR2;
                else
                    pos_next = POS_HUNT;
            end
            POS_LOW:
            begin
                low_next = rx_byte;
                pos_next = POS_LOW_CHK;
            end
            POS_LOW_CHK:
            begin
                low_ok_next = (low_reg == inv_byte);
                pos_next    = POS_HIGH;
            end
            POS_HIGH:
            begin
                high_next = rx_byte;
                pos_next  = POS_HIGH_CHK;
            end
            POS_HIGH_CHK:
            begin
                // Both complement checks decide the packet on its last byte.
                if (low_ok_reg && (high_reg == inv_byte))
                begin
                    result.packet_status = STATUS_GOOD;
                    result.data_word     = {high_reg, low_reg};
                end
                else
                begin
                    result.packet_status = STATUS_BAD;
                end
                pos_next = POS_HUNT;
            end
            default:
            begin
                pos_next = (rx_byte == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            low_reg    <= 8'h00;
            low_ok_reg <= 1'b0;
            high_reg   <= 8'h00;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            low_reg    <= low_next;
            low_ok_reg <= low_ok_next;
            high_reg   <= high_next;
        end
    end

endmodule

@@ hdl/remote_packet_deframer.sv @@
// Remote packet deframer top level: input register, framer and result register.
//
// The block takes one received byte per word on the rx channel and returns
// exactly one result word per byte on the pkt channel. A packet is the header
// 0xFF 0x55 followed by the low data byte, its complement, the high data byte
// and its complement. The result word of the sixth packet byte carries status
// good with the 16-bit data word, or status bad with a zero data word when a
// complement check failed. Every other byte yields status none and zero data.
//
// A byte accepted into the input register is decoded by the framer as it
// moves into the result register, from which its result is offered. The
// throughput is one byte per cycle while the receiver does not stall; the
// framer is a single byte-wide state machine, so nothing limits it further.
//
// Reset clears both pipeline valid flags and returns the framer to the header
// hunt. When the receiver stalls, the result register holds its word and the
// input register can still take one more byte before rx.ready drops, so the
// sender sees back-pressure one word after the receiver.
module remote_packet_deframer (
    input  logic          clk,
    input  logic          rst_n,
    rpd_byte_if.sink      rx,
    rpd_result_if.source  pkt
);
    import rpd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    framer_result;
    logic       out_free;
    logic       advance;

    // The result register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || pkt.ready;
    assign advance  = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || out_free;

    rpd_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (framer_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        if (advance)
            out_reg <= framer_result;
    end

    assign pkt.valid         = out_valid_reg;
    assign pkt.packet_status = out_reg.packet_status;
    assign pkt.data_word     = out_reg.data_word;

endmodule

@@ hdl/rpd_checker.sv @@
// Port-level assertions for the remote packet deframer, bound to the top level.
module rpd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             rx_ready,
    input logic             pkt_valid,
    input logic             pkt_ready,
    input rpd_pkg::status_t packet_status,
    input logic [15:0]      data_word
);
    import rpd_pkg::*;

    // A word with no good packet never carries data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && packet_status != STATUS_GOOD) |-> (data_word == 16'h0000))
        else $error("data_word set without a good packet");

    // Only the three defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |-> (packet_status == STATUS_NONE || packet_status == STATUS_GOOD
                       || packet_status == STATUS_BAD))
        else $error("undefined packet_status code");

    // A finished packet is never directly followed by another one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && pkt_ready && packet_status != STATUS_NONE)
        |=> !(pkt_valid && packet_status != STATUS_NONE))
        else $error("two packet completions in consecutive words");

    // A stalled result word holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && !pkt_ready) |=> (pkt_valid && $stable(packet_status)
                                       && $stable(data_word)))
        else $error("stalled result word changed");

    // Input back-pressure only appears while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> (pkt_valid && !pkt_ready))
        else $error("rx.ready low without an output stall");

endmodule

bind remote_packet_deframer rpd_checker u_rpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_ready      (rx.ready),
    .pkt_valid     (pkt.valid),
    .pkt_ready     (pkt.ready),
    .packet_status (pkt.packet_status),
    .data_word     (pkt.data_word)
);

@@ dv/remote_packet_deframer_tb.sv @@
// Self-checking testbench for the remote packet deframer with random idling on both channels.
module remote_packet_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rpd_pkg::*;

    // Framer position while walking through a six-byte packet. The block never
    // reaches values 6 and 7; the predictor treats them like the hunt.
    typedef enum logic [2:0] {
        POS_HUNT     = 3'd0,
        POS_SYNC     = 3'd1,
        POS_LOW      = 3'd2,
        POS_LOW_INV  = 3'd3,
        POS_HIGH     = 3'd4,
        POS_HIGH_INV = 3'd5
    } frame_pos_t;

    // The slowest run is far below this: ~700 words, each with a sender gap
    // and a receiver stall drawn from pick_gap, plus the pipeline latency.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_BYTES  = 650;
    localparam int unsigned DRAIN_CYCLES  = 8;

    logic clk = 1'b0;
    logic rst_n;

    rpd_byte_if   rx ();
    rpd_result_if pkt ();

    remote_packet_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .pkt   (pkt)
    );

    always #6 clk = ~clk;

    // Predictor state: a private copy of the framer registers.
    frame_pos_t  frame_pos;
    logic [7:0]  low_byte;
    logic        low_inv_ok;
    logic [7:0]  high_byte;

    // Results predicted for accepted bytes, oldest first.
    result_t     packet_results[$];

    // Idling controls, changed now and then so that some stretches run flat out.
    bit          rx_gaps_on;
    bit          pkt_stalls_on;

    int unsigned bytes_sent;
    int unsigned good_seen;
    int unsigned bad_seen;
    int unsigned fail_count;
    int unsigned cycle_count = 0;

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Advances the predicted framer by one received byte and returns the
    // result word that the block owes for it.
    function automatic result_t deframe_byte(input logic [7:0] value);
        result_t res;
        res.packet_status = STATUS_NONE;
        res.data_word     = 16'h0000;
        case (frame_pos)
            POS_SYNC:
            begin
                // A second 0xFF keeps the hunt armed; anything else but the
                // second header byte drops back to the hunt.
                if (value == HDR_SECOND)
                    frame_pos = POS_LOW;
                else if (value == HDR_FIRST)
                    frame_pos = POS_SYNC;
                else
                    frame_pos = POS_HUNT;
            end
            POS_LOW:
            begin
                low_byte  = value;
                frame_pos = POS_LOW_INV;
            end
            POS_LOW_INV:
            begin
                low_inv_ok = (low_byte == ~value);
                frame_pos  = POS_HIGH;
            end
            POS_HIGH:
            begin
                high_byte = value;
                frame_pos = POS_HIGH_INV;
            end
            POS_HIGH_INV:
            begin
                // Both complement checks are applied only at the last byte.
                if (low_inv_ok && high_byte == ~value)
                begin
                    res.packet_status = STATUS_GOOD;
                    res.data_word     = {high_byte, low_byte};
                end
                else
                begin
                    res.packet_status = STATUS_BAD;
                end
                frame_pos = POS_HUNT;
            end
            default:
            begin
                frame_pos = (value == HDR_FIRST) ? POS_SYNC : POS_HUNT;
            end
        endcase
        return res;
    endfunction

    // Offers one byte on the rx channel, after an optional idle gap, and
    // records the predicted result once the word has been accepted. The
    // ready level read right after the edge is the one the edge sampled.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = rx_gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            rx.valid   <= 1'b0;
            rx.rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= value;
        do
            @(posedge clk);
        while (!rx.ready);
        packet_results.push_back(deframe_byte(value));
        bytes_sent++;
    endtask

    // Sends a full packet: header, then data bytes and the given check bytes.
    task automatic send_packet(input logic [7:0] lo, input logic [7:0] lo_inv,
                               input logic [7:0] hi, input logic [7:0] hi_inv);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(lo);
        send_byte(lo_inv);
        send_byte(hi);
        send_byte(hi_inv);
    endtask

    // Header hunt: a second header byte while hunting, a repeated header
    // start, and a header mismatch that must fall back to the hunt.
    task automatic test_header_hunt();
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(8'h12);
        send_byte(8'h00);
    endtask

    // Good packets with extreme data, and header bytes carried as data.
    task automatic test_good_packets();
        send_packet(8'h00, 8'hFF, 8'hFF, 8'h00);
        send_packet(HDR_FIRST, 8'h00, HDR_SECOND, 8'hAA);
    endtask

    // Bad packets: a failed low check, then a failed high check. Both must
    // come back with a zero data word.
    task automatic test_bad_packets();
        send_packet(8'h00, 8'h00, 8'h00, 8'hFF);
        send_packet(8'h34, 8'hCB, 8'h12, 8'h12);
    endtask

    // Random stream: mostly well-formed packets with random content, mixed
    // with corrupted checks, broken headers, cut-off packets and noise.
    task automatic test_random_stream();
        int unsigned stop_at;
        int unsigned kind;
        int unsigned sel;
        int unsigned count;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  lo_inv;
        logic [7:0]  hi_inv;
        logic [7:0]  noise;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(7) == 0)
            begin
                rx_gaps_on    = 1'($urandom_range(1));
                pkt_stalls_on = 1'($urandom_range(1));
            end
            lo = 8'($urandom);
            hi = 8'($urandom);
            if ($urandom_range(9) == 0)
                lo = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(9) == 0)
                hi = $urandom_range(1) ? 8'hFF : 8'h00;
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                send_packet(lo, ~lo, hi, ~hi);
            end
            else if (kind < 75)
            begin
                // Corrupt the low check, the high check, or both.
                sel    = $urandom_range(2);
                lo_inv = ~lo;
                hi_inv = ~hi;
                if (sel != 1)
                    lo_inv = lo_inv ^ 8'($urandom_range(1, 255));
                if (sel != 0)
                    hi_inv = hi_inv ^ 8'($urandom_range(1, 255));
                send_packet(lo, lo_inv, hi, hi_inv);
            end
            else if (kind < 85)
            begin
                // Header start, perhaps repeated, then any byte at all.
                send_byte(HDR_FIRST);
                if ($urandom_range(1))
                    send_byte(HDR_FIRST);
                send_byte(8'($urandom));
            end
            else if (kind < 93)
            begin
                // A packet cut short: the next header is taken as data.
                count = $urandom_range(1, 3);
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                repeat (count) send_byte(8'($urandom));
            end
            else
            begin
                count = $urandom_range(1, 4);
                repeat (count)
                begin
                    sel   = $urandom_range(3);
                    noise = (sel == 0) ? HDR_FIRST : (sel == 1) ? HDR_SECOND : 8'($urandom);
                    send_byte(noise);
                end
            end
        end
    endtask

    // Result side: checks every accepted result word against the oldest
    // prediction, and drives pkt.ready with random stalls. This is the only
    // process that drives pkt.ready, once per edge at most.
    initial
    begin
        result_t     want;
        int unsigned stall_left;
        stall_left = 0;
        pkt.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pkt.valid && pkt.ready)
            begin
                if (packet_results.size() == 0)
                begin
                    $display("%0t: result word with nothing outstanding, status %0d data %h",
                             $time, pkt.packet_status, pkt.data_word);
                    fail_count++;
                end
                else
                begin
                    want = packet_results.pop_front();
                    if (pkt.packet_status !== want.packet_status)
                    begin
                        $display("%0t: packet_status mismatch, expected %0d, actual %0d",
                                 $time, want.packet_status, pkt.packet_status);
                        fail_count++;
                    end
                    if (pkt.data_word !== want.data_word)
                    begin
                        $display("%0t: data_word mismatch, expected %h, actual %h",
                                 $time, want.data_word, pkt.data_word);
                        fail_count++;
                    end
                    if (want.packet_status == STATUS_GOOD)
                        good_seen++;
                    else if (want.packet_status == STATUS_BAD)
                        bad_seen++;
                end
            end
            if (stall_left == 0 && pkt_stalls_on)
                stall_left = pick_gap();
            if (stall_left != 0)
            begin
                pkt.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pkt.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("remote_packet_deframer_tb failed");
            $finish;
        end
    end

    initial
    begin
        bytes_sent    = 0;
        good_seen     = 0;
        bad_seen      = 0;
        fail_count    = 0;
        frame_pos     = POS_HUNT;
        low_byte      = 8'h00;
        low_inv_ok    = 1'b0;
        high_byte     = 8'h00;
        rx_gaps_on    = 1'b0;
        pkt_stalls_on = 1'b0;
        rst_n        <= 1'b0;
        rx.valid     <= 1'b0;
        rx.rx_byte   <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The header hunt runs without idling, the other directed cases with it.
        test_header_hunt();
        rx_gaps_on    = 1'b1;
        pkt_stalls_on = 1'b1;
        test_good_packets();
        test_bad_packets();
        test_random_stream();

        rx.valid <= 1'b0;
        while (packet_results.size() != 0)
            @(posedge clk);
        // Give the pipeline time to show any extra word it should not send.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: header hunt, good and bad packets, then a random stream.",
                 bytes_sent);
        $display("Checked %0d good and %0d bad packets under random gaps and stalls.",
                 good_seen, bad_seen);
        if (fail_count == 0)
            $display("remote_packet_deframer_tb passed");
        else
            $display("remote_packet_deframer_tb failed");
        $finish;
    end

endmodule

@@ remote_packet_deframer.f @@
hdl/rpd_pkg.sv
hdl/rpd_if.sv
hdl/rpd_framer.sv
hdl/remote_packet_deframer.sv
hdl/rpd_checker.sv
dv/remote_packet_deframer_tb.sv
